@@ rtl/core/pfdc_pkg.sv @@
`default_nettype none
package pfdc_pkg;
	localparam int CAPACITY_DEF = 1024;
	localparam int LIMIT_W = 11;
	localparam int LIMIT_RESET = 1024;
	localparam int ENTRY_W = 64;

	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_FWD = 2'd1;
	localparam logic [1:0] ACT_CNT = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] source;
		logic [15:0] destination;
		logic [31:0] timestamp;
		logic [31:0] start_time;
		logic [31:0] end_time;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] out_source;
		logic [15:0] out_destination;
		logic [31:0] out_timestamp;
		logic [10:0] match_count;
	} out_item_t;
endpackage
`default_nettype wire

@@ rtl/core/pfdc_ram.sv @@
`default_nettype none
module pfdc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/core/pfdc_ctrl.sv @@
`default_nettype none
module pfdc_ctrl #(
	parameter int CAPACITY = pfdc_pkg::CAPACITY_DEF,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire pfdc_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output pfdc_pkg::out_item_t       out_data,
	input  wire logic [pfdc_pkg::LIMIT_W-1:0] limit,
	output logic                      mem_we,
	output logic [AW-1:0]             mem_waddr,
	output logic [pfdc_pkg::ENTRY_W-1:0] mem_wdata,
	output logic [AW-1:0]             mem_raddr,
	input  wire logic [pfdc_pkg::ENTRY_W-1:0] mem_rdata
);
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DONE = 4'b0100,
		ST_POP  = 4'b1000
	} state_t;

	state_t state_q;
	pfdc_pkg::in_item_t req_q;
	logic [AW-1:0] oldest_q, newest_q, rd_ptr_q;
	logic [CW-1:0] occ_q, issued_q;
	logic dup_q;
	logic [10:0] cnt_q;
	logic out_valid_q;
	pfdc_pkg::out_item_t out_q;
	logic rd_pending_q;

	logic [CW-1:0] lim_eff;
	logic [63:0] key;
	logic [AW-1:0] rd_next;
	logic hit_dup, hit_cnt;

	assign key = {req_q.source, req_q.destination, req_q.timestamp};
	assign rd_next = (32'(rd_ptr_q) + 1 >= CAPACITY) ? '0 : rd_ptr_q + AW'(1);
	assign hit_dup = rd_pending_q && (mem_rdata == key);
	assign hit_cnt = rd_pending_q && (mem_rdata[47:32] == req_q.destination)
		&& (mem_rdata[31:0] >= req_q.start_time) && (mem_rdata[31:0] <= req_q.end_time);

	always_comb begin
		if (limit == '0) begin
			lim_eff = CW'(1);
		end else if (32'(limit) > CAPACITY) begin
			lim_eff = CW'(CAPACITY);
		end else begin
			lim_eff = CW'(limit);
		end
	end

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
		nxt = (32'(i) + 1 >= CAPACITY) ? '0 : i + AW'(1);
	endfunction

	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign mem_raddr = (state_q == ST_IDLE) ? oldest_q : rd_ptr_q;
	assign mem_we = (state_q == ST_DONE) && (req_q.action == pfdc_pkg::ACT_ADD) && !dup_q;
	assign mem_waddr = newest_q;
	assign mem_wdata = key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			oldest_q <= '0;
			newest_q <= '0;
			occ_q <= '0;
			out_valid_q <= 1'b0;
			rd_pending_q <= 1'b0;
			req_q <= '0;
			dup_q <= 1'b0;
			cnt_q <= '0;
			rd_ptr_q <= '0;
			issued_q <= '0;
			out_q <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						req_q <= in_data;
						dup_q <= 1'b0;
						cnt_q <= '0;
						rd_ptr_q <= nxt(oldest_q);
						issued_q <= (occ_q != '0) ? CW'(1) : '0;
						rd_pending_q <= (occ_q != '0);
						if (in_data.action == pfdc_pkg::ACT_FWD) begin
							state_q <= ST_POP;
						end else if (in_data.action inside
							{pfdc_pkg::ACT_ADD, pfdc_pkg::ACT_CNT}) begin
							state_q <= ST_SCAN;
						end else begin
							out_q <= '0;
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (hit_dup) begin
						dup_q <= 1'b1;
					end
					if (hit_cnt) begin
						cnt_q <= cnt_q + 11'd1;
					end
					if (issued_q < occ_q && !(req_q.action == pfdc_pkg::ACT_ADD && hit_dup)) begin
						rd_ptr_q <= rd_next;
						issued_q <= issued_q + CW'(1);
						rd_pending_q <= 1'b1;
					end else begin
						rd_pending_q <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					out_q <= '{ok: (req_q.action == pfdc_pkg::ACT_ADD) && !dup_q,
						out_source: '0, out_destination: '0, out_timestamp: '0,
						match_count: (req_q.action == pfdc_pkg::ACT_ADD) ? '0 : cnt_q};
					if (req_q.action == pfdc_pkg::ACT_ADD) begin
						if (!dup_q) begin
							newest_q <= nxt(newest_q);
							if (occ_q >= lim_eff) begin
								oldest_q <= nxt(oldest_q);
							end else begin
								occ_q <= occ_q + CW'(1);
							end
						end
					end
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_POP: begin
					if (occ_q != '0) begin
						out_q <= '{ok: 1'b1, out_source: mem_rdata[63:48],
							out_destination: mem_rdata[47:32],
							out_timestamp: mem_rdata[31:0], match_count: '0};
						oldest_q <= nxt(oldest_q);
						occ_q <= occ_q - CW'(1);
					end else begin
						out_q <= '0;
					end
					rd_pending_q <= 1'b0;
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/packet_fifo_dedup_counter.sv @@
// packet_fifo_dedup_counter: bounded packet queue with duplicate refusal
// and a destination/time window counter.
// input channel in_valid/in_ready carries one request transaction
// (add, forward, count); output channel out_valid/out_ready returns one
// result transaction per request.
// cfg_we/cfg_wdata write capacity_limit at any edge; write only while idle.
// packets live in a single-port-read synchronous RAM, one read per cycle.
// add and count scan every held entry through the SCAN and DONE states,
// add stopping early on a duplicate; forward returns through the POP
// state, and code 3 is valid at the accepting edge. one request is in
// flight at a time; the next request is accepted only after the result
// is taken.
// reset empties the queue and sets capacity_limit to 1024; RAM contents
// are not cleared, only data from held entries is ever used.
// while a result waits on out_ready no new request is accepted.
`default_nettype none
module packet_fifo_dedup_counter #(
	parameter int CAPACITY = pfdc_pkg::CAPACITY_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire pfdc_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output pfdc_pkg::out_item_t      out_data,
	input  wire logic                cfg_we,
	input  wire logic [pfdc_pkg::LIMIT_W-1:0] cfg_wdata
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [pfdc_pkg::LIMIT_W-1:0] limit_q;
	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [pfdc_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= pfdc_pkg::LIMIT_W'(pfdc_pkg::LIMIT_RESET);
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	pfdc_ram #(.WIDTH(pfdc_pkg::ENTRY_W), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	pfdc_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.limit(limit_q),
		.mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr), .mem_rdata(mem_rdata)
	);

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("accept while result pending");
	a_fwd_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ok |-> out_data.match_count == '0)
		else $error("ok with count");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("back to back accept");
endmodule
`default_nettype wire
